[rtl/rmt_pkg.sv]
// Shared types and constants for the running median tracker.
package rmt_pkg;

    localparam int SAMPLE_W      = 31;
    localparam int SUM_W         = 16;
    localparam int MOD_STEPS     = 16;
    localparam int MOD_CNT_W     = 4;
    localparam logic [SUM_W-1:0] MODULUS_RESET = 16'd10000;

    // Command broadcast to every cell of one chain.
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [SAMPLE_W-1:0] data;
    } rmt_cmd_t;

endpackage

[rtl/running_median_tracker_unit.sv]
// Running median tracker: top level with control, two sorted chains and modulo unit.
//
// Usage: each word on the input channel (in_valid/in_ready, sample) yields one
// word on the output channel (out_valid/out_ready, median, median_sum,
// store_full). The samples are kept in two sorted cell chains: the lower half
// in descending order, the upper half in ascending order, so the lower median
// always sits at the head of the lower chain. A sample is inserted on acceptance
// and the chains are then rebalanced.
// Steps for a stored sample from acceptance to out_valid: insert, rebalance,
// start of the remainder unit, the remainder unit itself, which reduces
// (sum + median) by sum_modulus two bits per cycle, then taking the remainder
// and loading the output register. A sample that finds the store full goes
// straight to the output register. One word is in flight at a time, so the
// next word is accepted only once the result is in the output register.
// The configuration channel (cfg_valid/cfg_ready, sum_modulus) is always
// ready; write it only while no word is in flight. A modulus of 0 means 2^16.
// Reset empties the store, clears the running sum and sets the modulus to
// 10000. When the receiver stalls, the result holds in the output register
// while the next word may be accepted and worked on up to its result.
module running_median_tracker_unit
    import rmt_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SUM_W-1:0]    sum_modulus,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] median,
    output logic [SUM_W-1:0]    median_sum,
    output logic                store_full
);

    localparam int NCELL = CAPACITY / 2 + 1;
    localparam int CW    = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BAL  = 3'd1;
    localparam logic [2:0] S_MED  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       lsize_reg, lsize_next;
    logic [CW-1:0]       usize_reg, usize_next;
    logic [SUM_W-1:0]    modulus_reg, modulus_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] med_reg, med_next;
    logic                full_reg, full_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_med_reg, out_med_next;
    logic [SUM_W-1:0]    out_sum_reg, out_sum_next;
    logic                out_full_reg, out_full_next;

    rmt_cmd_t            lo_cmd;
    rmt_cmd_t            up_cmd;
    logic [SAMPLE_W-1:0] lo_head;
    logic [SAMPLE_W-1:0] up_head;
    logic                mod_start;
    logic [31:0]         mod_dividend;
    logic                mod_done;
    logic [SUM_W-1:0]    mod_rem;
    logic                in_fire;
    logic                is_full;

    rmt_chain #(
        .NCELL   (NCELL),
        .DESCEND (1'b1)
    ) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lo_cmd),
        .head  (lo_head)
    );

    rmt_chain #(
        .NCELL   (NCELL),
        .DESCEND (1'b0)
    ) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (up_cmd),
        .head  (up_head)
    );

    rmt_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .modulus  (modulus_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign is_full      = ({1'b0, lsize_reg} + {1'b0, usize_reg}) >= (CW + 1)'(CAPACITY);
    assign mod_dividend = 32'(sum_reg) + 32'(lo_head);

    always_comb
    begin
        state_next     = state_reg;
        lsize_next     = lsize_reg;
        usize_next     = usize_reg;
        modulus_next   = modulus_reg;
        sum_next       = sum_reg;
        med_next       = med_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_med_next   = out_med_reg;
        out_sum_next   = out_sum_reg;
        out_full_next  = out_full_reg;
        lo_cmd         = '0;
        up_cmd         = '0;
        mod_start      = 1'b0;

        if (cfg_valid)
        begin
            modulus_next = sum_modulus;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_full)
                    begin
                        // drop the word, report the held median
                        med_next   = lo_head;
                        full_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        full_next = 1'b0;
                        if (lsize_reg == '0 || sample <= lo_head)
                        begin
                            lo_cmd.push = 1'b1;
                            lo_cmd.data = sample;
                            lsize_next  = lsize_reg + 1'b1;
                        end
                        else
                        begin
                            up_cmd.push = 1'b1;
                            up_cmd.data = sample;
                            usize_next  = usize_reg + 1'b1;
                        end
                        state_next = S_BAL;
                    end
                end
            end
            S_BAL:
            begin
                // keep the lower half equal to or one larger than the upper half
                if ({1'b0, lsize_reg} > ({1'b0, usize_reg} + 1'b1))
                begin
                    lo_cmd.pop  = 1'b1;
                    up_cmd.push = 1'b1;
                    up_cmd.data = lo_head;
                    lsize_next  = lsize_reg - 1'b1;
                    usize_next  = usize_reg + 1'b1;
                end
                else if (usize_reg > lsize_reg)
                begin
                    up_cmd.pop  = 1'b1;
                    lo_cmd.push = 1'b1;
                    lo_cmd.data = up_head;
                    usize_next  = usize_reg - 1'b1;
                    lsize_next  = lsize_reg + 1'b1;
                end
                state_next = S_MED;
            end
            S_MED:
            begin
                med_next   = lo_head;
                mod_start  = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    sum_next   = mod_rem;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_med_next   = med_reg;
                    out_sum_next   = sum_reg;
                    out_full_next  = full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lsize_reg     <= '0;
            usize_reg     <= '0;
            modulus_reg   <= MODULUS_RESET;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lsize_reg     <= lsize_next;
            usize_reg     <= usize_next;
            modulus_reg   <= modulus_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg      <= med_next;
        full_reg     <= full_next;
        out_med_reg  <= out_med_next;
        out_sum_reg  <= out_sum_next;
        out_full_reg <= out_full_next;
    end

    assign out_valid  = out_valid_reg;
    assign median     = out_med_reg;
    assign median_sum = out_sum_reg;
    assign store_full = out_full_reg;

endmodule

[rtl/rmt_cell.sv]
// One cell of a sorted chain: holds one sample and a valid bit.
module rmt_cell
    import rmt_pkg::*;
#(
    parameter bit DESCEND = 1'b0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rmt_cmd_t            cmd,
    input  logic                is_head,
    input  logic                left_valid,
    input  logic [SAMPLE_W-1:0] left_data,
    input  logic                right_valid,
    input  logic [SAMPLE_W-1:0] right_data,
    output logic                valid,
    output logic [SAMPLE_W-1:0] data
);

    logic                valid_reg;
    logic                valid_next;
    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;
    logic                new_before_own;
    logic                new_before_left;

    // New word goes ahead of a held word only when strictly ahead in order.
    assign new_before_own  = DESCEND ? (cmd.data > data_reg)  : (cmd.data < data_reg);
    assign new_before_left = DESCEND ? (cmd.data > left_data) : (cmd.data < left_data);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.push)
        begin
            valid_next = valid_reg | left_valid | is_head;
            if (valid_reg && !new_before_own)
            begin
                data_next = data_reg;
            end
            else if (is_head || !left_valid || !new_before_left)
            begin
                data_next = cmd.data;
            end
            else
            begin
                data_next = left_data;
            end
        end
        else if (cmd.pop)
        begin
            // advance toward the head
            valid_next = right_valid;
            data_next  = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[rtl/rmt_chain.sv]
// Row of sorted cells with push and pop at the head end.
module rmt_chain
    import rmt_pkg::*;
#(
    parameter int NCELL   = 513,
    parameter bit DESCEND = 1'b0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rmt_cmd_t            cmd,
    output logic [SAMPLE_W-1:0] head
);

    logic [NCELL-1:0]               cell_valid;
    logic [NCELL-1:0][SAMPLE_W-1:0] cell_data;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic                lv;
        logic [SAMPLE_W-1:0] ld;
        logic                rv;
        logic [SAMPLE_W-1:0] rd;

        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign ld = '0;
        end
        else
        begin : g_mid
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == NCELL - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
        end
        else
        begin : g_inner
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
        end

        rmt_cell #(
            .DESCEND (DESCEND)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .is_head     (i == 0),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[i]),
            .data        (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

[rtl/rmt_mod.sv]
// Iterative remainder unit: 32-bit value modulo a 16-bit modulus, two bits a cycle.
module rmt_mod
    import rmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [SUM_W-1:0] modulus,
    output logic             done,
    output logic [SUM_W-1:0] rem
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic [31:0]          quo_reg;
    logic [31:0]          quo_next;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     rem_next;
    logic [SUM_W:0]       mod_eff;
    logic [SUM_W:0]       t1;
    logic [SUM_W:0]       r1;
    logic [SUM_W:0]       t2;
    logic [SUM_W:0]       r2;

    // zero modulus acts as 2^16
    assign mod_eff = (modulus == '0) ? {1'b1, {SUM_W{1'b0}}} : {1'b0, modulus};

    always_comb
    begin
        t1 = {rem_reg, quo_reg[31]};
        r1 = (t1 >= mod_eff) ? (t1 - mod_eff) : t1;
        t2 = {r1[SUM_W-1:0], quo_reg[30]};
        r2 = (t2 >= mod_eff) ? (t2 - mod_eff) : t2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[29:0], 2'b00};
            rem_next = r2[SUM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
